### sv/hms_pkg.sv
// Package with shared types, modulus constants and decimal digit helpers for the HMS clock.
`default_nettype none

package hms_pkg;

	// Moduli of the time fields, signed so that borrows compare cleanly.
	localparam logic signed [7:0] SEC_MOD  = 8'sd60;
	localparam logic signed [7:0] MIN_MOD  = 8'sd60;
	localparam logic signed [7:0] HOUR_MOD = 8'sd24;

	// Front-panel key flags of one beat.
	typedef struct packed {
		logic play;
		logic stop;
		logic eject;
		logic next;
		logic prev;
		logic ff;
		logic rew;
	} keys_t;

	// Clock state: time of day and run flag.
	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic       run;
	} clock_t;

	// Tens digit of a value in 0..59, found by a short compare chain.
	function automatic logic [2:0] tens_digit(input logic [5:0] v);
		logic [2:0] t;
		if (v >= 6'd50) begin
			t = 3'd5;
		end else if (v >= 6'd40) begin
			t = 3'd4;
		end else if (v >= 6'd30) begin
			t = 3'd3;
		end else if (v >= 6'd20) begin
			t = 3'd2;
		end else if (v >= 6'd10) begin
			t = 3'd1;
		end else begin
			t = 3'd0;
		end
		return t;
	endfunction

	// Ones digit: the value less ten times its tens digit (times ten as two shifts).
	function automatic logic [3:0] ones_digit(input logic [5:0] v, input logic [2:0] t);
		logic [5:0] t_ext;
		logic [5:0] diff;
		t_ext = {3'b000, t};
		diff  = v - ((t_ext << 3) + (t_ext << 1));
		return diff[3:0];
	endfunction

endpackage

`default_nettype wire

### sv/hms_step.sv
// Next-state logic of the HMS clock: key action, second tick and carry/borrow ripple.
`default_nettype none

module hms_step (
	input  wire hms_pkg::keys_t  keys,
	input  wire hms_pkg::clock_t cur,
	output hms_pkg::clock_t      nxt
);

	logic signed [7:0] h;
	logic signed [7:0] m;
	logic signed [7:0] s;
	logic              run;

	always_comb begin
		h   = signed'({3'b000, cur.hour});
		m   = signed'({2'b00, cur.minute});
		s   = signed'({2'b00, cur.second});
		run = cur.run;

		// Only the highest-priority pressed key acts.
		if (keys.play) begin
			run = 1'b1;
		end else if (keys.stop) begin
			run = 1'b0;
		end else if (keys.eject) begin
			h = 8'sd0;
			m = 8'sd0;
			s = 8'sd0;
		end else if (keys.next) begin
			h = h + 8'sd1;
		end else if (keys.prev) begin
			h = h - 8'sd1;
		end else if (keys.ff) begin
			m = m + 8'sd1;
		end else if (keys.rew) begin
			m = m - 8'sd1;
		end

		// A running clock counts one second.
		if (run) begin
			s = s + 8'sd1;
		end

		// Seconds can only overflow by one step.
		if (s >= hms_pkg::SEC_MOD) begin
			s = s - hms_pkg::SEC_MOD;
			m = m + 8'sd1;
		end

		// Minutes lie in -1..61 here: one carry or borrow into the hours.
		if (m >= hms_pkg::MIN_MOD) begin
			m = m - hms_pkg::MIN_MOD;
			h = h + 8'sd1;
		end else if (m < 8'sd0) begin
			m = m + hms_pkg::MIN_MOD;
			h = h - 8'sd1;
		end

		// Hours lie in -1..25 here and wrap modulo 24.
		if (h >= hms_pkg::HOUR_MOD) begin
			h = h - hms_pkg::HOUR_MOD;
		end else if (h < 8'sd0) begin
			h = h + hms_pkg::HOUR_MOD;
		end
	end

	assign nxt = '{hour: h[4:0], minute: m[5:0], second: s[5:0], run: run};

endmodule

`default_nettype wire

### sv/hms_clock_with_set_keys_top.sv
// Top level of the HMS time-of-day clock with front-panel set keys.
//
// Usage: each input beat is one pass of the panel loop and carries seven key
// flags; the block returns exactly one result beat per input beat, with the
// time after the update in binary, as six decimal digits, and the run flag.
// Both channels use valid/ready; a beat moves when valid and ready are high.
// Path: an accepted beat lands in the input register. When the result
// register is free or being drained, the beat moves on: the clock state and
// the result register update from it, and its result is offered.
// Throughput: one beat per cycle while out_ready is high. The state update
// is one pass of the key/carry logic between the input and result registers.
// Stall: while the receiver holds out_ready low, the result register holds
// its beat, the input register keeps one more beat, and in_ready drops once
// both are full; no beat is lost or repeated.
// Reset: arst_n low clears the valid flags of both registers and sets the
// time to 00:00:00 with the clock running.
`default_nettype none

module hms_clock_with_set_keys_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       key_play,
	input  wire logic       key_stop,
	input  wire logic       key_eject,
	input  wire logic       key_next,
	input  wire logic       key_prev,
	input  wire logic       key_ff,
	input  wire logic       key_rew,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [4:0]      hour_value,
	output logic [5:0]      minute_value,
	output logic [5:0]      second_value,
	output logic            is_running,
	output logic [1:0]      hour_tens,
	output logic [3:0]      hour_ones,
	output logic [2:0]      minute_tens,
	output logic [3:0]      minute_ones,
	output logic [2:0]      second_tens,
	output logic [3:0]      second_ones
);

	hms_pkg::keys_t  keys_s1;
	logic            valid_s1;
	hms_pkg::clock_t state_q;
	hms_pkg::clock_t state_nxt;
	logic            advance;
	logic [2:0]      h_tens;
	logic [2:0]      m_tens;
	logic [2:0]      s_tens;

	// Stage 1 moves on when the result register is free or being drained.
	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			keys_s1 <= '{play: key_play, stop: key_stop, eject: key_eject,
				next: key_next, prev: key_prev, ff: key_ff, rew: key_rew};
		end
	end

	// Key action, tick and ripple on the current state.
	hms_step u_step (
		.keys (keys_s1),
		.cur  (state_q),
		.nxt  (state_nxt)
	);

	// Clock state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{hour: 5'd0, minute: 6'd0, second: 6'd0, run: 1'b1};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Decimal digits of the new time.
	assign h_tens = hms_pkg::tens_digit({1'b0, state_nxt.hour});
	assign m_tens = hms_pkg::tens_digit(state_nxt.minute);
	assign s_tens = hms_pkg::tens_digit(state_nxt.second);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hour_value   <= state_nxt.hour;
			minute_value <= state_nxt.minute;
			second_value <= state_nxt.second;
			is_running   <= state_nxt.run;
			hour_tens    <= h_tens[1:0];
			hour_ones    <= hms_pkg::ones_digit({1'b0, state_nxt.hour}, h_tens);
			minute_tens  <= m_tens;
			minute_ones  <= hms_pkg::ones_digit(state_nxt.minute, m_tens);
			second_tens  <= s_tens;
			second_ones  <= hms_pkg::ones_digit(state_nxt.second, s_tens);
		end
	end

	// The stored time always stays a legal time of day.
	a_state_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.hour < 5'd24) && (state_q.minute < 6'd60) && (state_q.second < 6'd60))
		else $error("clock state out of range");

	// The state changes only when a beat leaves the input register.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("clock state changed without a beat");

	// The offered result matches the stored state.
	a_out_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hour_value == state_q.hour) && (minute_value == state_q.minute)
			&& (second_value == state_q.second) && (is_running == state_q.run))
		else $error("result beat disagrees with clock state");

	// Second digits match the binary value; other ones digits stay below ten.
	a_digits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({4'd0, second_tens} * 7'd10 + {3'd0, second_ones}
			== {1'b0, second_value}) && (minute_ones < 4'd10) && (hour_ones < 4'd10))
		else $error("decimal digits inconsistent");

	// A held input beat is not dropped while stage 1 is full and stalled.
	a_stall_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("stalled beat lost from input register");

endmodule

`default_nettype wire

### sim/hms_clock_with_set_keys_top_test.sv
// Self-checking testbench of the HMS time-of-day clock with front-panel set keys.

module hms_clock_with_set_keys_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD = 10;
	localparam int DECIMAL_BASE = 10;
	localparam int DRAIN_CYCLES = 6;
	localparam int CYCLE_LIMIT = 500000;
	localparam int MAX_REPORTS = 40;

	// Key patterns, one bit per key, in priority order from play down to rew.
	localparam hms_pkg::keys_t KEY_NONE  = 7'b000_0000;
	localparam hms_pkg::keys_t KEY_PLAY  = 7'b100_0000;
	localparam hms_pkg::keys_t KEY_STOP  = 7'b010_0000;
	localparam hms_pkg::keys_t KEY_EJECT = 7'b001_0000;
	localparam hms_pkg::keys_t KEY_NEXT  = 7'b000_1000;
	localparam hms_pkg::keys_t KEY_PREV  = 7'b000_0100;
	localparam hms_pkg::keys_t KEY_FF    = 7'b000_0010;
	localparam hms_pkg::keys_t KEY_REW   = 7'b000_0001;

	// One displayed time, as the block returns it.
	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic       run;
		logic [1:0] hour_tens;
		logic [3:0] hour_ones;
		logic [2:0] minute_tens;
		logic [3:0] minute_ones;
		logic [2:0] second_tens;
		logic [3:0] second_ones;
	} time_beat_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic       key_play;
	logic       key_stop;
	logic       key_eject;
	logic       key_next;
	logic       key_prev;
	logic       key_ff;
	logic       key_rew;
	logic       out_valid;
	logic       out_ready = 1'b1;
	logic [4:0] hour_value;
	logic [5:0] minute_value;
	logic [5:0] second_value;
	logic       is_running;
	logic [1:0] hour_tens;
	logic [3:0] hour_ones;
	logic [2:0] minute_tens;
	logic [3:0] minute_ones;
	logic [2:0] second_tens;
	logic [3:0] second_ones;

	hms_pkg::clock_t now_clock;
	time_beat_t      expected_times[$];
	int              mismatch_count = 0;
	int              cycle_count = 0;
	bit              tx_gaps_on;
	bit              rx_stalls_on;

	hms_clock_with_set_keys_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.key_play     (key_play),
		.key_stop     (key_stop),
		.key_eject    (key_eject),
		.key_next     (key_next),
		.key_prev     (key_prev),
		.key_ff       (key_ff),
		.key_rew      (key_rew),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hour_value   (hour_value),
		.minute_value (minute_value),
		.second_value (second_value),
		.is_running   (is_running),
		.hour_tens    (hour_tens),
		.hour_ones    (hour_ones),
		.minute_tens  (minute_tens),
		.minute_ones  (minute_ones),
		.second_tens  (second_tens),
		.second_ones  (second_ones)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t ns: timeout with %0d times still expected", $time,
				expected_times.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Apply one key beat to the predicted clock and queue the time it should show.
	task automatic advance_clock(input hms_pkg::keys_t k);
		int         h;
		int         m;
		int         s;
		time_beat_t beat;
		h = now_clock.hour;
		m = now_clock.minute;
		s = now_clock.second;
		if (k.play) begin
			now_clock.run = 1'b1;
		end else if (k.stop) begin
			now_clock.run = 1'b0;
		end else if (k.eject) begin
			h = 0;
			m = 0;
			s = 0;
		end else if (k.next) begin
			h++;
		end else if (k.prev) begin
			h--;
		end else if (k.ff) begin
			m++;
		end else if (k.rew) begin
			m--;
		end
		if (now_clock.run) begin
			s++;
		end
		// Ripple the carries and borrows up through the fields.
		if (s >= hms_pkg::SEC_MOD) begin
			s -= hms_pkg::SEC_MOD;
			m++;
		end
		if (m >= hms_pkg::MIN_MOD) begin
			m -= hms_pkg::MIN_MOD;
			h++;
		end else if (m < 0) begin
			m += hms_pkg::MIN_MOD;
			h--;
		end
		h = (h + hms_pkg::HOUR_MOD) % hms_pkg::HOUR_MOD;
		now_clock.hour = 5'(h);
		now_clock.minute = 6'(m);
		now_clock.second = 6'(s);
		beat.hour = now_clock.hour;
		beat.minute = now_clock.minute;
		beat.second = now_clock.second;
		beat.run = now_clock.run;
		beat.hour_tens = 2'(h / DECIMAL_BASE);
		beat.hour_ones = 4'(h % DECIMAL_BASE);
		beat.minute_tens = 3'(m / DECIMAL_BASE);
		beat.minute_ones = 4'(m % DECIMAL_BASE);
		beat.second_tens = 3'(s / DECIMAL_BASE);
		beat.second_ones = 4'(s % DECIMAL_BASE);
		expected_times.push_back(beat);
	endtask

	// Offer one key beat, with an occasional gap before it, and wait for acceptance.
	task automatic send_keys(input hms_pkg::keys_t k);
		int unsigned gap;
		if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 13);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		key_play <= k.play;
		key_stop <= k.stop;
		key_eject <= k.eject;
		key_next <= k.next;
		key_prev <= k.prev;
		key_ff <= k.ff;
		key_rew <= k.rew;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		advance_clock(k);
	endtask

	// Stop offering beats and wait until every expected time has come back.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_times.size() != 0) @(posedge clk);
	endtask

	// Random key pattern: mostly idle passes, then single keys, then mixed presses.
	function automatic hms_pkg::keys_t random_keys();
		hms_pkg::keys_t k;
		int unsigned    pick;
		k = KEY_NONE;
		pick = $urandom_range(0, 99);
		if (pick >= 88) begin
			k = hms_pkg::keys_t'(7'($urandom_range(0, 127)));
			// Keep eject rare so the seconds get a chance to wrap.
			if ($urandom_range(0, 1) == 1) begin
				k.eject = 1'b0;
			end
		end else if (pick >= 60) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3: begin
					k = KEY_PLAY;
				end
				4, 5: begin
					k = KEY_STOP;
				end
				6: begin
					k = KEY_EJECT;
				end
				7, 8, 9, 10: begin
					k = KEY_NEXT;
				end
				11, 12, 13, 14: begin
					k = KEY_PREV;
				end
				15, 16, 17: begin
					k = KEY_FF;
				end
				default: begin
					k = KEY_REW;
				end
			endcase
		end
		return k;
	endfunction

	// Run the clock until the predicted seconds sit at 59; the clock must be running.
	task automatic run_to_second_59();
		while (now_clock.second != 6'(hms_pkg::SEC_MOD - 1)) send_keys(KEY_NONE);
	endtask

	// Each key alone, including the hour and minute wraps and eject in both run states.
	task automatic test_single_keys();
		send_keys(KEY_NONE);
		send_keys(KEY_STOP);
		send_keys(KEY_PREV);
		send_keys(KEY_NEXT);
		send_keys(KEY_REW);
		send_keys(KEY_FF);
		send_keys(KEY_FF);
		send_keys(KEY_EJECT);
		send_keys(KEY_NONE);
		send_keys(KEY_PLAY);
		send_keys(KEY_EJECT);
		send_keys(KEY_NEXT);
		send_keys(KEY_PREV);
		send_keys(KEY_FF);
		send_keys(KEY_REW);
	endtask

	// Several keys at once: only the highest-priority one may act.
	task automatic test_key_priority();
		send_keys(KEY_STOP | KEY_EJECT | KEY_NEXT | KEY_PREV | KEY_FF | KEY_REW);
		send_keys(KEY_PLAY | KEY_STOP | KEY_EJECT | KEY_NEXT | KEY_PREV | KEY_FF | KEY_REW);
		send_keys(KEY_EJECT | KEY_NEXT | KEY_PREV | KEY_FF | KEY_REW);
		send_keys(KEY_NEXT | KEY_PREV | KEY_FF | KEY_REW);
		send_keys(KEY_PREV | KEY_FF | KEY_REW);
		send_keys(KEY_FF | KEY_REW);
		send_keys(KEY_PLAY | KEY_REW);
	endtask

	// Second carries that ripple into minutes and hours, alone and on top of key steps.
	task automatic test_carry_chains();
		// Full rollover from 23:59:59 to midnight.
		send_keys(KEY_STOP);
		send_keys(KEY_EJECT);
		send_keys(KEY_REW);
		send_keys(KEY_PLAY);
		run_to_second_59();
		send_keys(KEY_NONE);
		// Minute step in the same pass as a second carry.
		run_to_second_59();
		send_keys(KEY_FF);
		run_to_second_59();
		send_keys(KEY_REW);
		// Hour step past 23 together with a carry from 59:59.
		send_keys(KEY_STOP);
		send_keys(KEY_EJECT);
		send_keys(KEY_REW);
		send_keys(KEY_PLAY);
		run_to_second_59();
		send_keys(KEY_NEXT);
		// Hour step below zero together with a carry from 59:59.
		send_keys(KEY_STOP);
		send_keys(KEY_EJECT);
		send_keys(KEY_REW);
		send_keys(KEY_NEXT);
		send_keys(KEY_PLAY);
		run_to_second_59();
		send_keys(KEY_PREV);
	endtask

	// Random key beats, held for a few passes as a real panel would see them.
	task automatic test_random_traffic(input int unsigned beats, input bit with_idling);
		hms_pkg::keys_t k;
		int unsigned    hold;
		hold = 0;
		k = KEY_NONE;
		tx_gaps_on = with_idling;
		rx_stalls_on = with_idling;
		for (int unsigned i = 0; i < beats; i++) begin
			if (with_idling && i % 100 == 0) begin
				tx_gaps_on = ($urandom_range(0, 3) != 0);
				rx_stalls_on = ($urandom_range(0, 3) != 0);
			end
			// Let the pipeline empty out now and then before going on.
			if (with_idling && i % 250 == 249) begin
				drain_results();
			end
			if (hold == 0) begin
				k = random_keys();
				hold = $urandom_range(1, 4);
			end
			send_keys(k);
			hold--;
		end
	endtask

	// Receiver: ready by default, with random stall bursts.
	always begin : drive_out_ready
		int unsigned stall_len;
		@(negedge clk);
		if (arst_n && rx_stalls_on && $urandom_range(0, 9) == 0) begin
			stall_len = $urandom_range(1, 13);
			out_ready <= 1'b0;
			repeat (stall_len) @(negedge clk);
			out_ready <= 1'b1;
		end
	end

	// Compare one field of a result beat.
	task automatic check_field(input string field, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			if (mismatch_count < MAX_REPORTS) begin
				$display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
			end
			mismatch_count++;
		end
	endtask

	// Check every accepted result beat against the oldest expected time.
	always @(posedge clk) begin : check_results
		time_beat_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (expected_times.size() == 0) begin
				if (mismatch_count < MAX_REPORTS) begin
					$display("%0t ns: expected no beat, got %0d:%0d:%0d run %0d", $time,
						hour_value, minute_value, second_value, is_running);
				end
				mismatch_count++;
			end else begin
				want = expected_times.pop_front();
				check_field("hour_value", want.hour, hour_value);
				check_field("minute_value", want.minute, minute_value);
				check_field("second_value", want.second, second_value);
				check_field("is_running", want.run, is_running);
				check_field("hour_tens", want.hour_tens, hour_tens);
				check_field("hour_ones", want.hour_ones, hour_ones);
				check_field("minute_tens", want.minute_tens, minute_tens);
				check_field("minute_ones", want.minute_ones, minute_ones);
				check_field("second_tens", want.second_tens, second_tens);
				check_field("second_ones", want.second_ones, second_ones);
			end
		end
	end

	// Test sequence.
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		key_play = 1'b0;
		key_stop = 1'b0;
		key_eject = 1'b0;
		key_next = 1'b0;
		key_prev = 1'b0;
		key_ff = 1'b0;
		key_rew = 1'b0;
		tx_gaps_on = 1'b1;
		rx_stalls_on = 1'b1;
		now_clock = '{hour: 5'd0, minute: 6'd0, second: 6'd0, run: 1'b1};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_single_keys();
		test_key_priority();
		test_carry_chains();
		test_random_traffic(1120, 1'b1);
		test_random_traffic(400, 1'b0);

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

### files.f
sv/hms_pkg.sv
sv/hms_step.sv
sv/hms_clock_with_set_keys_top.sv
sim/hms_clock_with_set_keys_top_test.sv
